@@ sv/pwmma_pkg.sv @@
// Shared types, constants and helper functions for the packet word statistics block.
package pwmma_pkg;

    // Words per beat, and words counted on the second beat of a packet.
    localparam int BEAT_WORDS   = 16;
    localparam int SECOND_WORDS = 11;
    localparam int WORD_WIDTH   = 16;
    localparam int LANE_WIDTH   = 64;
    localparam int BSUM_WIDTH   = 20;
    localparam int BCNT_WIDTH   = 5;
    localparam int SUM_WIDTH    = 32;
    localparam int STEP_WIDTH   = $clog2(SUM_WIDTH);

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_WIDTH-1:0] WORD_MIN_INIT = 16'hFFFF;
    localparam logic [WORD_WIDTH-1:0] WORD_ZERO     = 16'h0000;

    // Position of a beat inside its packet.
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_STREAM
    } t_phase;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        BK_RUN,
        BK_DIV,
        BK_DONE
    } t_back_state;

    // One classified beat with its partial statistics.
    typedef struct packed {
        logic [LANE_WIDTH-1:0] word0;
        logic [LANE_WIDTH-1:0] word1;
        logic [LANE_WIDTH-1:0] word2;
        logic [LANE_WIDTH-1:0] word3;
        logic                  eop;
        logic                  stats_end;
        logic [WORD_WIDTH-1:0] bmax;
        logic [WORD_WIDTH-1:0] bmin;
        logic [BSUM_WIDTH-1:0] bsum;
        logic [BCNT_WIDTH-1:0] bcnt;
    } t_entry;

    // One result beat.
    typedef struct packed {
        logic [LANE_WIDTH-1:0] word0;
        logic [LANE_WIDTH-1:0] word1;
        logic [LANE_WIDTH-1:0] word2;
        logic [LANE_WIDTH-1:0] word3;
        logic                  eop;
    } t_result;

    // Byte swap of a 16-bit word (big-endian on the wire).
    function automatic logic [WORD_WIDTH-1:0] swap16(input logic [WORD_WIDTH-1:0] v);
        swap16 = {v[7:0], v[15:8]};
    endfunction

endpackage

@@ sv/packet_word_max_min_avg_core.sv @@
// Top level of the packet word max, min and average block.
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+------------------------------------------------
//  Input    | push / full         | i_beat_word0..3, i_end_of_packet
//  Result   | empty / pop         | o_out_word0..3, o_out_end_of_packet
//
// A beat that is not a counted packet end moves from push through the queue and the
// result register to the result ports; such beats pass one per cycle while results
// are taken and no packet end is being finished. A counted last beat holds the back
// part while it merges, runs the bit-serial divider for the average and loads the
// result register. Meanwhile the two-entry queue keeps taking transfers until full.
// Reset clears the beat position, the statistics, the queue and the result valid.
// A stalled result waits in the result register while the queue keeps filling.
module packet_word_max_min_avg_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_beat_word0,
    input  logic [63:0] i_beat_word1,
    input  logic [63:0] i_beat_word2,
    input  logic [63:0] i_beat_word3,
    input  logic        i_end_of_packet,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_out_word0,
    output logic [63:0] o_out_word1,
    output logic [63:0] o_out_word2,
    output logic [63:0] o_out_word3,
    output logic        o_out_end_of_packet
);

    logic               q_push;
    logic               q_pop;
    logic               q_empty;
    pwmma_pkg::t_entry  front_entry;
    pwmma_pkg::t_entry  head_entry;
    pwmma_pkg::t_result result;

    // Front part: beat position and per-beat reduction.
    pwmma_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_q_full        (full),
        .i_beat_word0    (i_beat_word0),
        .i_beat_word1    (i_beat_word1),
        .i_beat_word2    (i_beat_word2),
        .i_beat_word3    (i_beat_word3),
        .i_end_of_packet (i_end_of_packet),
        .o_q_push        (q_push),
        .o_entry         (front_entry)
    );

    // Queue between the two parts.
    pwmma_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_entry (head_entry)
    );

    // Back part: accumulation, divider and result register.
    pwmma_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_entry   (head_entry),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_out_word0         = result.word0;
    assign o_out_word1         = result.word1;
    assign o_out_word2         = result.word2;
    assign o_out_word3         = result.word3;
    assign o_out_end_of_packet = result.eop;

endmodule

@@ sv/pwmma_front.sv @@
// Front part: tracks the beat position, masks the second beat and reduces each beat's words.
module pwmma_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_q_full,
    input  logic [63:0]           i_beat_word0,
    input  logic [63:0]           i_beat_word1,
    input  logic [63:0]           i_beat_word2,
    input  logic [63:0]           i_beat_word3,
    input  logic                  i_end_of_packet,
    output logic                  o_q_push,
    output pwmma_pkg::t_entry     o_entry
);

    pwmma_pkg::t_phase r_phase;
    pwmma_pkg::t_phase n_phase;

    logic [255:0]                      beat;
    logic                              count_all;
    logic                              count_part;
    logic [pwmma_pkg::WORD_WIDTH-1:0]  mx0 [16];
    logic [pwmma_pkg::WORD_WIDTH-1:0]  mn0 [16];
    logic [pwmma_pkg::BSUM_WIDTH-1:0]  s0  [16];
    logic [pwmma_pkg::WORD_WIDTH-1:0]  mx1 [8];
    logic [pwmma_pkg::WORD_WIDTH-1:0]  mn1 [8];
    logic [pwmma_pkg::BSUM_WIDTH-1:0]  s1  [8];
    logic [pwmma_pkg::WORD_WIDTH-1:0]  mx2 [4];
    logic [pwmma_pkg::WORD_WIDTH-1:0]  mn2 [4];
    logic [pwmma_pkg::BSUM_WIDTH-1:0]  s2  [4];
    logic [pwmma_pkg::WORD_WIDTH-1:0]  mx3 [2];
    logic [pwmma_pkg::WORD_WIDTH-1:0]  mn3 [2];
    logic [pwmma_pkg::BSUM_WIDTH-1:0]  s3  [2];

    assign beat       = {i_beat_word3, i_beat_word2, i_beat_word1, i_beat_word0};
    assign count_all  = (r_phase == pwmma_pkg::PH_STREAM);
    assign count_part = (r_phase == pwmma_pkg::PH_SECOND);
    assign o_q_push   = i_push && !i_q_full;

    // Per-word values; words that are not counted enter as neutral elements.
    always_comb begin
        logic [pwmma_pkg::WORD_WIDTH-1:0] v;
        logic                             inc;
        for (int k = 0; k < pwmma_pkg::BEAT_WORDS; k++) begin
            v   = pwmma_pkg::swap16(beat[16*k +: 16]);
            inc = count_all || (count_part && (k < pwmma_pkg::SECOND_WORDS));
            mx0[k] = inc ? v : pwmma_pkg::WORD_ZERO;
            mn0[k] = inc ? v : pwmma_pkg::WORD_MIN_INIT;
            s0[k]  = inc ? pwmma_pkg::BSUM_WIDTH'(v) : '0;
        end
    end

    // Reduction tree: four levels of max, min and add.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            mx1[k] = (mx0[2*k] > mx0[2*k+1]) ? mx0[2*k] : mx0[2*k+1];
            mn1[k] = (mn0[2*k] < mn0[2*k+1]) ? mn0[2*k] : mn0[2*k+1];
            s1[k]  = s0[2*k] + s0[2*k+1];
        end
        for (int k = 0; k < 4; k++) begin
            mx2[k] = (mx1[2*k] > mx1[2*k+1]) ? mx1[2*k] : mx1[2*k+1];
            mn2[k] = (mn1[2*k] < mn1[2*k+1]) ? mn1[2*k] : mn1[2*k+1];
            s2[k]  = s1[2*k] + s1[2*k+1];
        end
        for (int k = 0; k < 2; k++) begin
            mx3[k] = (mx2[2*k] > mx2[2*k+1]) ? mx2[2*k] : mx2[2*k+1];
            mn3[k] = (mn2[2*k] < mn2[2*k+1]) ? mn2[2*k] : mn2[2*k+1];
            s3[k]  = s2[2*k] + s2[2*k+1];
        end
    end

    // Queue entry: forwarded beat, flags and partial statistics.
    always_comb begin
        o_entry.word0     = i_beat_word0;
        o_entry.word1     = i_beat_word1;
        o_entry.word2     = count_part ? {pwmma_pkg::WORD_ZERO, i_beat_word2[47:0]}
                                       : i_beat_word2;
        o_entry.word3     = i_beat_word3;
        o_entry.eop       = i_end_of_packet;
        o_entry.stats_end = count_all && i_end_of_packet;
        o_entry.bmax      = (mx3[0] > mx3[1]) ? mx3[0] : mx3[1];
        o_entry.bmin      = (mn3[0] < mn3[1]) ? mn3[0] : mn3[1];
        o_entry.bsum      = s3[0] + s3[1];
        if (count_all) begin
            o_entry.bcnt = pwmma_pkg::BCNT_WIDTH'(pwmma_pkg::BEAT_WORDS);
        end else if (count_part) begin
            o_entry.bcnt = pwmma_pkg::BCNT_WIDTH'(pwmma_pkg::SECOND_WORDS);
        end else begin
            o_entry.bcnt = '0;
        end
    end

    // Beat position inside the packet; a last flag counts only from the third beat on.
    always_comb begin
        n_phase = r_phase;
        if (o_q_push) begin
            unique case (r_phase)
                pwmma_pkg::PH_FIRST:  n_phase = pwmma_pkg::PH_SECOND;
                pwmma_pkg::PH_SECOND: n_phase = pwmma_pkg::PH_STREAM;
                default: begin
                    n_phase = i_end_of_packet ? pwmma_pkg::PH_FIRST : pwmma_pkg::PH_STREAM;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pwmma_pkg::PH_FIRST;
        end else begin
            r_phase <= n_phase;
        end
    end

    // A counted last beat returns the position to the packet start.
    a_eop_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && o_entry.stats_end) |=> (r_phase == pwmma_pkg::PH_FIRST))
        else $error("phase did not restart after a counted last beat");

    // Only beats from the third on may close the statistics.
    a_stats_end_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry.stats_end |-> (o_entry.bcnt == pwmma_pkg::BCNT_WIDTH'(pwmma_pkg::BEAT_WORDS)))
        else $error("statistics end flagged on a partly counted beat");

endmodule

@@ sv/pwmma_queue.sv @@
// Short queue of classified beats between the front and back parts.
module pwmma_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pwmma_pkg::t_entry  i_entry,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output pwmma_pkg::t_entry  o_entry
);

    pwmma_pkg::t_entry                r_mem [pwmma_pkg::QUEUE_DEPTH];
    logic [pwmma_pkg::QPTR_WIDTH-1:0] r_wr_ptr;
    logic [pwmma_pkg::QPTR_WIDTH-1:0] r_rd_ptr;
    logic [pwmma_pkg::QCNT_WIDTH-1:0] r_count;
    logic [pwmma_pkg::QCNT_WIDTH-1:0] n_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full  = (r_count == pwmma_pkg::QCNT_WIDTH'(pwmma_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Fill level follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // The pointers stay apart by exactly the fill level.
    a_ptr_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == pwmma_pkg::QPTR_WIDTH'(r_count))
        else $error("queue pointers disagree with the fill level");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pwmma_pkg::QCNT_WIDTH'(pwmma_pkg::QUEUE_DEPTH))
        else $error("queue fill level beyond its depth");

endmodule

@@ sv/pwmma_back.sv @@
// Back part: accumulates statistics, divides at packet end and holds the result beat.
module pwmma_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  pwmma_pkg::t_entry  i_entry,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output pwmma_pkg::t_result o_result
);

    pwmma_pkg::t_back_state            r_state;
    pwmma_pkg::t_back_state            n_state;
    logic [pwmma_pkg::WORD_WIDTH-1:0]  r_max;
    logic [pwmma_pkg::WORD_WIDTH-1:0]  n_max;
    logic [pwmma_pkg::WORD_WIDTH-1:0]  r_min;
    logic [pwmma_pkg::WORD_WIDTH-1:0]  n_min;
    logic [pwmma_pkg::SUM_WIDTH-1:0]   r_sum;
    logic [pwmma_pkg::SUM_WIDTH-1:0]   n_sum;
    logic [COUNT_WIDTH-1:0]            r_cnt;
    logic [COUNT_WIDTH-1:0]            n_cnt;
    logic [pwmma_pkg::STEP_WIDTH-1:0]  r_step;
    logic [pwmma_pkg::STEP_WIDTH-1:0]  n_step;
    logic [COUNT_WIDTH-1:0]            r_rem;
    logic [COUNT_WIDTH-1:0]            n_rem;
    logic [pwmma_pkg::SUM_WIDTH-1:0]   r_quo;
    logic [pwmma_pkg::SUM_WIDTH-1:0]   n_quo;
    pwmma_pkg::t_result                r_hold;
    pwmma_pkg::t_result                n_hold;
    pwmma_pkg::t_result                r_out;
    pwmma_pkg::t_result                n_out;
    logic                              r_out_vld;
    logic                              n_out_vld;

    logic                              slot_free;
    logic [pwmma_pkg::WORD_WIDTH-1:0]  acc_max;
    logic [pwmma_pkg::WORD_WIDTH-1:0]  acc_min;
    logic [pwmma_pkg::SUM_WIDTH-1:0]   acc_sum;
    logic [COUNT_WIDTH-1:0]            acc_cnt;
    logic [COUNT_WIDTH:0]              div_shift;
    logic                              div_ge;
    logic [COUNT_WIDTH:0]              div_diff;

    assign o_empty   = !r_out_vld;
    assign o_result  = r_out;
    assign slot_free = !r_out_vld || i_pop;

    // Running statistics merged with the head entry's partial results.
    assign acc_max = (i_entry.bmax > r_max) ? i_entry.bmax : r_max;
    assign acc_min = (i_entry.bmin < r_min) ? i_entry.bmin : r_min;
    assign acc_sum = r_sum + pwmma_pkg::SUM_WIDTH'(i_entry.bsum);
    assign acc_cnt = r_cnt + COUNT_WIDTH'(i_entry.bcnt);

    // One restoring divide step: sum over count, one quotient bit a cycle.
    assign div_shift = {r_rem, r_quo[pwmma_pkg::SUM_WIDTH-1]};
    assign div_ge    = (div_shift >= {1'b0, r_cnt});
    assign div_diff  = div_shift - {1'b0, r_cnt};

    // Sequencer: take beats, run the divider at packet end, then emit the statistics.
    always_comb begin
        n_state   = r_state;
        n_max     = r_max;
        n_min     = r_min;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_step    = r_step;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_hold    = r_hold;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_pop;
        o_q_pop   = 1'b0;
        unique case (r_state)
            pwmma_pkg::BK_RUN: begin
                if (!i_q_empty && slot_free) begin
                    o_q_pop = 1'b1;
                    n_max   = acc_max;
                    n_min   = acc_min;
                    n_sum   = acc_sum;
                    n_cnt   = acc_cnt;
                    n_hold  = '{word0: i_entry.word0, word1: i_entry.word1,
                                word2: i_entry.word2, word3: i_entry.word3,
                                eop: i_entry.eop};
                    if (i_entry.stats_end) begin
                        n_state = pwmma_pkg::BK_DIV;
                        n_step  = pwmma_pkg::STEP_WIDTH'(pwmma_pkg::SUM_WIDTH - 1);
                        n_rem   = '0;
                        n_quo   = acc_sum;
                    end else begin
                        n_out     = n_hold;
                        n_out_vld = 1'b1;
                    end
                end
            end
            pwmma_pkg::BK_DIV: begin
                n_rem  = div_ge ? div_diff[COUNT_WIDTH-1:0] : div_shift[COUNT_WIDTH-1:0];
                n_quo  = {r_quo[pwmma_pkg::SUM_WIDTH-2:0], div_ge};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = pwmma_pkg::BK_DONE;
                end
            end
            pwmma_pkg::BK_DONE: begin
                if (slot_free) begin
                    n_out       = r_hold;
                    n_out.word0 = {pwmma_pkg::swap16(r_quo[15:0]),
                                   pwmma_pkg::swap16(r_cnt[15:0]),
                                   pwmma_pkg::swap16(r_min),
                                   pwmma_pkg::swap16(r_max)};
                    n_out_vld   = 1'b1;
                    n_max       = pwmma_pkg::WORD_ZERO;
                    n_min       = pwmma_pkg::WORD_MIN_INIT;
                    n_sum       = '0;
                    n_cnt       = '0;
                    n_state     = pwmma_pkg::BK_RUN;
                end
            end
            default: begin
                n_state = pwmma_pkg::BK_RUN;
            end
        endcase
    end

    // Control and statistics registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pwmma_pkg::BK_RUN;
            r_out_vld <= 1'b0;
            r_max     <= pwmma_pkg::WORD_ZERO;
            r_min     <= pwmma_pkg::WORD_MIN_INIT;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_step    <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_max     <= n_max;
            r_min     <= n_min;
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
            r_step    <= n_step;
        end
    end

    // Payload and divider data registers.
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    // The queue is drained only while no packet end is being finished.
    a_pop_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == pwmma_pkg::BK_RUN))
        else $error("queue popped while the divider is busy");

    // The divider runs its full length before the result is emitted.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwmma_pkg::BK_DIV && r_step == '0) |=> (r_state == pwmma_pkg::BK_DONE))
        else $error("divider did not finish after its last step");

    // Statistics are cleared once the packet-end beat is loaded.
    a_stats_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwmma_pkg::BK_DONE && slot_free) |=> (r_cnt == '0 && r_sum == '0))
        else $error("statistics not cleared after packet end");

endmodule

@@ dv/packet_word_max_min_avg_core_checker.sv @@
`timescale 1ns / 100ps
// Checker for the packet word statistics block: predicts each forwarded beat and compares.
module packet_word_max_min_avg_core_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [63:0] i_beat_word0,
    input  logic [63:0] i_beat_word1,
    input  logic [63:0] i_beat_word2,
    input  logic [63:0] i_beat_word3,
    input  logic        i_end_of_packet,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [63:0] i_out_word0,
    input  logic [63:0] i_out_word1,
    input  logic [63:0] i_out_word2,
    input  logic [63:0] i_out_word3,
    input  logic        i_out_end_of_packet,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // Predicted block state: position in the packet and running statistics.
    pwmma_pkg::t_phase      beat_pos;
    logic [15:0]            word_max;
    logic [15:0]            word_min;
    logic [31:0]            word_sum;
    logic [COUNT_WIDTH-1:0] word_cnt;

    // Beats the block owes us, oldest first.
    pwmma_pkg::t_result beats_due[$];

    int fails       = 0;
    int pending_cnt = 0;
    int checked_cnt = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending_cnt;
    assign o_checked    = checked_cnt;

    // Words travel big-endian, so the numeric value has its bytes swapped.
    function automatic logic [15:0] to_wire16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    task automatic clear_stats();
        word_max = pwmma_pkg::WORD_ZERO;
        word_min = pwmma_pkg::WORD_MIN_INIT;
        word_sum = '0;
        word_cnt = '0;
    endtask

    // Fold the lowest n words of a beat into the running statistics.
    task automatic fold_words(input logic [255:0] beat, input int n);
        logic [15:0] v;
        for (int w = 0; w < n; w++) begin
            v = to_wire16(beat[16*w +: 16]);
            if (v > word_max) word_max = v;
            if (v < word_min) word_min = v;
            word_sum = word_sum + 32'(v);
            word_cnt = word_cnt + 1'b1;
        end
    endtask

    // Work out the forwarded beat for one accepted input beat and advance the state.
    task automatic forecast_beat(input pwmma_pkg::t_result in_beat,
                                 output pwmma_pkg::t_result out_beat);
        logic [255:0] flat;
        logic [15:0]  avg;
        out_beat = in_beat;
        flat = {in_beat.word3, in_beat.word2, in_beat.word1, in_beat.word0};
        case (beat_pos)
            pwmma_pkg::PH_FIRST: begin
                beat_pos = pwmma_pkg::PH_SECOND;
            end
            pwmma_pkg::PH_SECOND: begin
                // The top word of the third lane is blanked and not counted.
                out_beat.word2[63:48] = pwmma_pkg::WORD_ZERO;
                fold_words(flat, pwmma_pkg::SECOND_WORDS);
                beat_pos = pwmma_pkg::PH_STREAM;
            end
            default: begin
                fold_words(flat, pwmma_pkg::BEAT_WORDS);
                if (in_beat.eop) begin
                    // A zero count reads as all ones, like a plain restoring divider.
                    avg = (word_cnt != 0) ? 16'(word_sum / word_cnt) : 16'hFFFF;
                    out_beat.word0 = {to_wire16(avg), to_wire16(word_cnt[15:0]),
                                      to_wire16(word_min), to_wire16(word_max)};
                    clear_stats();
                    beat_pos = pwmma_pkg::PH_FIRST;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fails++;
        end
    endtask

    // Watch both channels at each rising edge; results are checked before new beats queue.
    always @(posedge i_clk) begin : watch
        pwmma_pkg::t_result got;
        pwmma_pkg::t_result want;
        pwmma_pkg::t_result fresh;
        if (!i_rst_n) begin
            beat_pos = pwmma_pkg::PH_FIRST;
            clear_stats();
            beats_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                got = '{i_out_word0, i_out_word1, i_out_word2, i_out_word3,
                        i_out_end_of_packet};
                if (beats_due.size() == 0) begin
                    $error("result transfer with no beat outstanding");
                    fails++;
                end else begin
                    want = beats_due.pop_front();
                    check_field("out_word0", want.word0, got.word0);
                    check_field("out_word1", want.word1, got.word1);
                    check_field("out_word2", want.word2, got.word2);
                    check_field("out_word3", want.word3, got.word3);
                    check_field("out_end_of_packet", 64'(want.eop), 64'(got.eop));
                    checked_cnt++;
                end
            end
            if (i_push && !i_full) begin
                fresh = '{i_beat_word0, i_beat_word1, i_beat_word2, i_beat_word3,
                          i_end_of_packet};
                forecast_beat(fresh, want);
                beats_due.push_back(want);
            end
        end
        pending_cnt = beats_due.size();
    end

endmodule

@@ dv/packet_word_max_min_avg_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the packet word statistics block: stimulus, idling mixes and verdict.
module packet_word_max_min_avg_core_tb;

    localparam int COUNT_WIDTH = 16;
    localparam int HOLD_LEN    = 200;
    localparam int TAIL_CYCLES = 60;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [63:0] i_beat_word0;
    logic [63:0] i_beat_word1;
    logic [63:0] i_beat_word2;
    logic [63:0] i_beat_word3;
    logic        i_end_of_packet;
    logic        empty;
    logic        pop;
    logic [63:0] o_out_word0;
    logic [63:0] o_out_word1;
    logic [63:0] o_out_word2;
    logic [63:0] o_out_word3;
    logic        o_out_end_of_packet;

    int fails;
    int pending;
    int results_checked;

    int send_idle_pct;
    int pop_stall_pct;
    int hold_asks   = 0;
    int hold_served = 0;
    int beats_sent  = 0;
    int packets_sent = 0;
    int cycle_count = 0;

    packet_word_max_min_avg_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_beat_word0       (i_beat_word0),
        .i_beat_word1       (i_beat_word1),
        .i_beat_word2       (i_beat_word2),
        .i_beat_word3       (i_beat_word3),
        .i_end_of_packet    (i_end_of_packet),
        .empty              (empty),
        .pop                (pop),
        .o_out_word0        (o_out_word0),
        .o_out_word1        (o_out_word1),
        .o_out_word2        (o_out_word2),
        .o_out_word3        (o_out_word3),
        .o_out_end_of_packet(o_out_end_of_packet)
    );

    packet_word_max_min_avg_core_checker #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_chk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_full             (full),
        .i_beat_word0       (i_beat_word0),
        .i_beat_word1       (i_beat_word1),
        .i_beat_word2       (i_beat_word2),
        .i_beat_word3       (i_beat_word3),
        .i_end_of_packet    (i_end_of_packet),
        .i_empty            (empty),
        .i_pop              (pop),
        .i_out_word0        (o_out_word0),
        .i_out_word1        (o_out_word1),
        .i_out_word2        (o_out_word2),
        .i_out_word3        (o_out_word3),
        .i_out_end_of_packet(o_out_end_of_packet),
        .o_fail_count       (fails),
        .o_pending          (pending),
        .o_checked          (results_checked)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("packet_word_max_min_avg_core verification failed");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    initial begin : result_sink
        int held;
        held = 0;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (held > 0) begin
                pop <= 1'b0;
                held--;
            end else if (hold_asks != hold_served) begin
                hold_served = hold_asks;
                held = HOLD_LEN - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= pop_stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_beat(input logic [63:0] w0, input logic [63:0] w1,
                             input logic [63:0] w2, input logic [63:0] w3,
                             input logic eop);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push            <= 1'b1;
        i_beat_word0    <= w0;
        i_beat_word1    <= w1;
        i_beat_word2    <= w2;
        i_beat_word3    <= w3;
        i_end_of_packet <= eop;
        do @(posedge i_clk); while (full);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Lane contents: mostly random, with saturated lanes and narrow value ranges mixed in.
    function automatic logic [63:0] make_lane();
        logic [63:0] lane;
        case ($urandom_range(7))
            0: lane = '1;
            1: lane = '0;
            2: begin
                for (int k = 0; k < 4; k++) begin
                    lane[16*k +: 16] = {8'($urandom), 8'($urandom_range(3))};
                end
            end
            default: lane = {$urandom, $urandom};
        endcase
        return lane;
    endfunction

    // A noisy packet carries a random last flag on every beat.
    task automatic send_packet(input int beats, input bit noisy);
        for (int b = 0; b < beats; b++) begin
            send_beat(make_lane(), make_lane(), make_lane(), make_lane(),
                      noisy ? 1'($urandom_range(1)) : (b == beats - 1));
        end
        packets_sent++;
    endtask

    // Mostly well-formed packets, some long ones, and a share of broken ones.
    task automatic run_mix(input int beats);
        int target;
        target = beats_sent + beats;
        while (beats_sent < target) begin
            case ($urandom_range(9))
                0:       send_packet($urandom_range(1, 4), 1'b1);
                1:       send_packet($urandom_range(10, 30), 1'b0);
                default: send_packet($urandom_range(3, 6), 1'b0);
            endcase
        end
    endtask

    // Stop offering beats until every outstanding result has transferred.
    task automatic wait_drained();
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        i_rst_n         = 1'b0;
        push            = 1'b0;
        i_beat_word0    = '0;
        i_beat_word1    = '0;
        i_beat_word2    = '0;
        i_beat_word3    = '0;
        i_end_of_packet = 1'b0;
        send_idle_pct   = 0;
        pop_stall_pct   = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // All-ones packet, then all-zeros packet: the word extremes.
        repeat (2) send_beat('1, '1, '1, '1, 1'b0);
        send_beat('1, '1, '1, '1, 1'b1);
        repeat (2) send_beat('0, '0, '0, '0, 1'b0);
        send_beat('0, '0, '0, '0, 1'b1);

        // Last flag on the first and second beats is ignored; the third beat closes.
        repeat (3) send_beat(make_lane(), make_lane(), make_lane(), make_lane(), 1'b1);

        // Byte order: 0x0100 and 0x0001 on the wire must fold as 1 and 256.
        send_beat(64'h0001_0100_0001_0100, '0, '0, '0, 1'b0);
        send_beat(64'h0100_0100_0001_0001, 64'h00FF_FF00_0100_0001,
                  64'hABCD_0100_FF00_00FF, '1, 1'b0);
        send_beat(64'h0001_0001_0001_0001, 64'h0100_0100_0100_0100,
                  64'h8000_0080_7FFF_FF7F, 64'h0000_FFFF_0001_0100, 1'b1);

        send_packet(6, 1'b0);

        // No idling on either side.
        run_mix(250);

        // Hold results back long enough that the block fills and stalls its input.
        hold_asks++;
        run_mix(40);
        wait_drained();

        send_idle_pct = 84;
        pop_stall_pct = 0;
        run_mix(250);

        send_idle_pct = 0;
        pop_stall_pct = 84;
        run_mix(250);

        send_idle_pct = 11;
        pop_stall_pct = 11;
        run_mix(250);

        // Drain, then leave time for any stray result to show up.
        pop_stall_pct = 0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats in %0d packets; %0d forwarded beats were checked.",
                 beats_sent, packets_sent, results_checked);
        $display("Covered word extremes, early last flags, broken packets, four idle mixes,");
        $display("and a %0d-cycle result hold that backed up the input.", HOLD_LEN);
        if (fails == 0 && pending == 0) begin
            $display("packet_word_max_min_avg_core verification clean");
        end else begin
            $display("packet_word_max_min_avg_core verification failed");
        end
        $finish;
    end

endmodule
